/* rtl/ssch_pkg.sv */
package ssch_pkg;

  // event codes
  localparam logic [2:0] CMD_NEW     = 3'd0;
  localparam logic [2:0] CMD_SLICE   = 3'd1;
  localparam logic [2:0] CMD_BLOCK   = 3'd2;
  localparam logic [2:0] CMD_UNBLOCK = 3'd3;
  localparam logic [2:0] CMD_TERM    = 3'd4;

  // error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_FULL    = 2'd1;
  localparam logic [1:0] ERR_DUP     = 2'd2;
  localparam logic [1:0] ERR_TICKETS = 2'd3;

  // pids at or above this are ignored
  localparam logic [16:0] PID_LIMIT = 17'd32768;

  // reset value of the stride numerator
  localparam logic [31:0] NUM_RESET = 32'd1000000;

  localparam int DIV_STEPS = 32;

  // sequencer states
  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_FIND_RD  = 19'h00002,
    S_FIND_CHK = 19'h00004,
    S_DISPATCH = 19'h00008,
    S_DIV      = 19'h00010,
    S_PASS_RD  = 19'h00020,
    S_PASS_WR  = 19'h00040,
    S_RM_RD    = 19'h00080,
    S_RM_CHK   = 19'h00100,
    S_SHL_RD   = 19'h00200,
    S_SHL_WR   = 19'h00400,
    S_INS_RD   = 19'h00800,
    S_INS_RD2  = 19'h01000,
    S_INS_CHK  = 19'h02000,
    S_SHR_RD   = 19'h04000,
    S_SHR_WR   = 19'h08000,
    S_HEAD     = 19'h10000,
    S_HEAD_RD2 = 19'h20000,
    S_HEAD_CHK = 19'h40000
  } state_t;

endpackage

/* rtl/ssch_div.sv */
module ssch_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        run_r,  run_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r,  cnt_nxt;
  logic [15:0] rem_r,  rem_nxt;
  logic [31:0] quo_r,  quo_nxt;
  logic [15:0] dvs_r,  dvs_nxt;
  logic [16:0] shifted;
  logic        ge;

  // one restoring step per cycle
  assign shifted = {rem_r, quo_r[31]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = ge ? 16'(shifted - {1'b0, dvs_r}) : shifted[15:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(ssch_pkg::DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/stride_scheduler.sv */
// Stride scheduler over a table of MAX_PROCS processes. Pulse start while busy is low to hand
// in one event word; busy stays high until the result word appears on the out_ ports for
// exactly one cycle with out_valid, and the receiver cannot stall it. busy covers pid search
// and dispatch, the stride divide of a new process, a pass update, removal from and
// re-insertion into the ready order as the event needs and the head lookup; the result
// word follows in the next cycle. The table memories, one write and one registered read
// each, are walked one entry per step. The user must write stride_numerator through
// cfg_write_en/cfg_write_data only while busy is low; the block does not enforce this.
module stride_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [14:0] in_pid,
  input  logic [15:0] in_tickets,
  input  logic [14:0] in_current_pid,
  input  logic        in_cpu_idle,
  output logic        out_valid,
  output logic        out_switch_valid,
  output logic [14:0] out_switch_pid,
  output logic [1:0]  out_error_code
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  ssch_pkg::state_t state_r, state_nxt;

  logic [31:0]          num_r;
  logic [MAX_PROCS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [IDX_W-1:0]     free_r, free_nxt;
  logic                 found_r, found_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [63:0]          new_pass_r, new_pass_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic [14:0]          pid_r, pid_nxt;
  logic [15:0]          tickets_r, tickets_nxt;
  logic [14:0]          cur_r, cur_nxt;
  logic                 idle_r, idle_nxt;
  logic                 out_valid_r;
  logic                 out_sw_r;
  logic [14:0]          out_pid_r;
  logic [1:0]           out_err_r;

  // table memories
  logic [14:0]      pid_mem  [MAX_PROCS];
  logic [31:0]      strd_mem [MAX_PROCS];
  logic [63:0]      pass_mem [MAX_PROCS];
  logic [IDX_W-1:0] ord_mem  [MAX_PROCS];

  logic [14:0]      pid_rd_r;
  logic [31:0]      strd_rd_r;
  logic [63:0]      pass_rd_r;
  logic [IDX_W-1:0] ord_rd_r;

  logic [IDX_W-1:0] pid_raddr, pass_raddr, ord_raddr;
  logic             pid_we, strd_we, pass_we, ord_we;
  logic [IDX_W-1:0] ord_waddr;
  logic [IDX_W-1:0] ord_wdata;
  logic [63:0]      pass_wdata;

  logic        div_start, div_done;
  logic [31:0] div_q;

  logic        fin;
  logic        fin_sw;
  logic [14:0] fin_pid;
  logic [1:0]  fin_err;

  logic             pid_ok;
  logic [IDX_W-1:0] find_idx;
  logic [63:0]      upd_pass;
  logic             report_en;

  ssch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (tickets_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pid_ok    = {2'b00, pid_r} < ssch_pkg::PID_LIMIT;
  assign find_idx  = pos_r[IDX_W-1:0];
  assign upd_pass  = (cmd_r == ssch_pkg::CMD_UNBLOCK) ? pass_rd_r :
                     pass_rd_r + {32'd0, strd_rd_r};
  assign report_en = (cmd_r inside {ssch_pkg::CMD_NEW, ssch_pkg::CMD_UNBLOCK}) ?
                     idle_r : 1'b1;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    slot_nxt       = slot_r;
    free_nxt       = free_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    new_pass_nxt   = new_pass_r;
    cmd_nxt        = cmd_r;
    pid_nxt        = pid_r;
    tickets_nxt    = tickets_r;
    cur_nxt        = cur_r;
    idle_nxt       = idle_r;
    pid_raddr      = ord_rd_r;
    pass_raddr     = ord_rd_r;
    ord_raddr      = pos_r[IDX_W-1:0];
    pid_we         = 1'b0;
    strd_we        = 1'b0;
    pass_we        = 1'b0;
    pass_wdata     = upd_pass;
    ord_we         = 1'b0;
    ord_waddr      = pos_r[IDX_W-1:0];
    ord_wdata      = ord_rd_r;
    div_start      = 1'b0;
    fin            = 1'b0;
    fin_sw         = 1'b0;
    fin_pid        = '0;
    fin_err        = ssch_pkg::ERR_OK;

    case (state_r)
      ssch_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt        = in_command;
          pid_nxt        = in_pid;
          tickets_nxt    = in_tickets;
          cur_nxt        = in_current_pid;
          idle_nxt       = in_cpu_idle;
          pos_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = ssch_pkg::S_FIND_RD;
        end
      end
      // walk the table for the pid and the first free entry
      ssch_pkg::S_FIND_RD: begin
        pid_raddr = find_idx;
        state_nxt = ssch_pkg::S_FIND_CHK;
      end
      ssch_pkg::S_FIND_CHK: begin
        if (used_r[find_idx] && pid_rd_r == pid_r) begin
          found_nxt = 1'b1;
          slot_nxt  = find_idx;
        end
        if (!used_r[find_idx] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_nxt       = find_idx;
        end
        if (pos_r == CNT_W'(MAX_PROCS - 1)) begin
          state_nxt = ssch_pkg::S_DISPATCH;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ssch_pkg::S_FIND_RD;
        end
      end
      // decide what the event does
      ssch_pkg::S_DISPATCH: begin
        pos_nxt = '0;
        if (!pid_ok) begin
          fin = 1'b1;
        end else begin
          case (cmd_r)
            ssch_pkg::CMD_NEW: begin
              if (found_r) begin
                fin     = 1'b1;
                fin_err = ssch_pkg::ERR_DUP;
              end else if (tickets_r == 16'd0) begin
                fin     = 1'b1;
                fin_err = ssch_pkg::ERR_TICKETS;
              end else if (!free_found_r) begin
                fin     = 1'b1;
                fin_err = ssch_pkg::ERR_FULL;
              end else begin
                div_start = 1'b1;
                slot_nxt  = free_r;
                state_nxt = ssch_pkg::S_DIV;
              end
            end
            ssch_pkg::CMD_SLICE, ssch_pkg::CMD_UNBLOCK: begin
              if (found_r) state_nxt = ssch_pkg::S_PASS_RD;
              else fin = 1'b1;
            end
            ssch_pkg::CMD_BLOCK, ssch_pkg::CMD_TERM: begin
              if (found_r) state_nxt = ssch_pkg::S_PASS_RD;
              else state_nxt = ssch_pkg::S_HEAD;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      // new entry once the stride is ready
      ssch_pkg::S_DIV: begin
        if (div_done) begin
          pid_we           = 1'b1;
          strd_we          = 1'b1;
          pass_we          = 1'b1;
          pass_wdata       = '0;
          used_nxt[slot_r] = 1'b1;
          new_pass_nxt     = '0;
          pos_nxt          = '0;
          state_nxt        = ssch_pkg::S_INS_RD;
        end
      end
      // pass update
      ssch_pkg::S_PASS_RD: begin
        pass_raddr = slot_r;
        state_nxt  = ssch_pkg::S_PASS_WR;
      end
      ssch_pkg::S_PASS_WR: begin
        new_pass_nxt = upd_pass;
        pass_we      = (cmd_r != ssch_pkg::CMD_UNBLOCK);
        if (cmd_r == ssch_pkg::CMD_TERM) used_nxt[slot_r] = 1'b0;
        pos_nxt   = '0;
        state_nxt = ssch_pkg::S_RM_RD;
      end
      // locate the slot in the ready order
      ssch_pkg::S_RM_RD: begin
        if (pos_r == count_r) begin
          pos_nxt = '0;
          if (cmd_r inside {ssch_pkg::CMD_UNBLOCK, ssch_pkg::CMD_SLICE}) begin
            state_nxt = ssch_pkg::S_INS_RD;
          end else begin
            state_nxt = ssch_pkg::S_HEAD;
          end
        end else begin
          state_nxt = ssch_pkg::S_RM_CHK;
        end
      end
      ssch_pkg::S_RM_CHK: begin
        if (ord_rd_r == slot_r) begin
          if (cmd_r == ssch_pkg::CMD_UNBLOCK) state_nxt = ssch_pkg::S_HEAD;
          else state_nxt = ssch_pkg::S_SHL_RD;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ssch_pkg::S_RM_RD;
        end
      end
      // close the gap left by the removed slot
      ssch_pkg::S_SHL_RD: begin
        if (({1'b0, pos_r} + 1'b1) >= {1'b0, count_r}) begin
          count_nxt = count_r - 1'b1;
          pos_nxt   = '0;
          if (cmd_r == ssch_pkg::CMD_SLICE) state_nxt = ssch_pkg::S_INS_RD;
          else state_nxt = ssch_pkg::S_HEAD;
        end else begin
          ord_raddr = IDX_W'(pos_r + 1'b1);
          state_nxt = ssch_pkg::S_SHL_WR;
        end
      end
      ssch_pkg::S_SHL_WR: begin
        ord_we    = 1'b1;
        pos_nxt   = pos_r + 1'b1;
        state_nxt = ssch_pkg::S_SHL_RD;
      end
      // find the insert place: after every entry with pass not above ours
      ssch_pkg::S_INS_RD: begin
        if (count_r == CNT_W'(MAX_PROCS)) begin
          state_nxt = ssch_pkg::S_HEAD;
        end else if (pos_r == count_r) begin
          idx_nxt   = count_r;
          state_nxt = ssch_pkg::S_SHR_RD;
        end else begin
          state_nxt = ssch_pkg::S_INS_RD2;
        end
      end
      ssch_pkg::S_INS_RD2: begin
        state_nxt = ssch_pkg::S_INS_CHK;
      end
      ssch_pkg::S_INS_CHK: begin
        if (pass_rd_r <= new_pass_r) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ssch_pkg::S_INS_RD;
        end else begin
          idx_nxt   = count_r;
          state_nxt = ssch_pkg::S_SHR_RD;
        end
      end
      // open a gap and drop the slot in
      ssch_pkg::S_SHR_RD: begin
        if (idx_r == pos_r) begin
          ord_we    = 1'b1;
          ord_wdata = slot_r;
          count_nxt = count_r + 1'b1;
          state_nxt = ssch_pkg::S_HEAD;
        end else begin
          ord_raddr = IDX_W'(idx_r - 1'b1);
          state_nxt = ssch_pkg::S_SHR_WR;
        end
      end
      ssch_pkg::S_SHR_WR: begin
        ord_we    = 1'b1;
        ord_waddr = idx_r[IDX_W-1:0];
        idx_nxt   = idx_r - 1'b1;
        state_nxt = ssch_pkg::S_SHR_RD;
      end
      // head of the ready order
      ssch_pkg::S_HEAD: begin
        if (!report_en || count_r == '0) begin
          fin = 1'b1;
        end else begin
          ord_raddr = '0;
          state_nxt = ssch_pkg::S_HEAD_RD2;
        end
      end
      ssch_pkg::S_HEAD_RD2: begin
        state_nxt = ssch_pkg::S_HEAD_CHK;
      end
      ssch_pkg::S_HEAD_CHK: begin
        fin    = 1'b1;
        fin_sw = idle_r || (cur_r != pid_rd_r);
        if (fin_sw) fin_pid = pid_rd_r;
      end
      default: begin
        state_nxt = ssch_pkg::S_IDLE;
      end
    endcase

    if (fin) state_nxt = ssch_pkg::S_IDLE;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssch_pkg::S_IDLE;
      num_r       <= ssch_pkg::NUM_RESET;
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
      if (cfg_write_en) num_r <= cfg_write_data;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    slot_r       <= slot_nxt;
    free_r       <= free_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    new_pass_r   <= new_pass_nxt;
    cmd_r        <= cmd_nxt;
    pid_r        <= pid_nxt;
    tickets_r    <= tickets_nxt;
    cur_r        <= cur_nxt;
    idle_r       <= idle_nxt;
    if (fin) begin
      out_sw_r  <= fin_sw;
      out_pid_r <= fin_pid;
      out_err_r <= fin_err;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (pid_we)  pid_mem[slot_r]  <= pid_r;
    if (strd_we) strd_mem[slot_r] <= div_q;
    if (pass_we) pass_mem[slot_r] <= pass_wdata;
    if (ord_we)  ord_mem[ord_waddr] <= ord_wdata;
    pid_rd_r  <= pid_mem[pid_raddr];
    strd_rd_r <= strd_mem[slot_r];
    pass_rd_r <= pass_mem[pass_raddr];
    ord_rd_r  <= ord_mem[ord_raddr];
  end

  assign busy             = (state_r != ssch_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_switch_valid = out_sw_r;
  assign out_switch_pid   = out_pid_r;
  assign out_error_code   = out_err_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PROCS))
    else $error("ready count above table size");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result word while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted event did not raise busy");

  a_err_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sw_r) |-> (out_err_r == ssch_pkg::ERR_OK))
    else $error("switch reported with an error");

  a_switch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sw_r) |-> (count_r != '0))
    else $error("switch reported with empty ready order");

endmodule
